[hw/rtl/rsi_pkg.sv]
// Shared widths and types for the ray/sphere intersection pipeline.
package rsi_pkg;

    // Coefficient widths
    localparam int A_W    = 64;   // a = d.d, unsigned
    localparam int H_W    = 66;   // h = d.L, signed
    localparam int C_W    = 67;   // c = L.L - r^2, signed
    localparam int DISC_W = 132;  // h^2 - a*c, signed

    // Square root over D * 2^32
    localparam int SQ_IN_W  = 164;
    localparam int SQ_OUT_W = SQ_IN_W / 2;
    localparam int SQ_REM_W = SQ_OUT_W + 2;

    // Numerator of the root and the quotient
    localparam int NUM_W = 84;
    localparam int Q_W   = 32;

    // Configuration register indexes
    localparam logic [1:0] CFG_CENTER_X = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [1:0] CFG_CENTER_Z = 2'd2;
    localparam logic [1:0] CFG_RADIUS   = 2'd3;

    // Sideband that rides along with each ray
    typedef struct packed {
        logic                    miss;
        logic                    near_root;
        logic signed [H_W-1:0]   h;
        logic        [A_W-1:0]   a;
    } t_side;

endpackage

[hw/rtl/rsi_front.sv]
// Front stages: offset, dot products, coefficients and discriminant.
module rsi_front
    import rsi_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_v,
    input  logic signed [31:0]        i_org [3],
    input  logic signed [31:0]        i_dir [3],
    input  logic signed [31:0]        i_cen [3],
    input  logic        [30:0]        i_rad,
    output logic                      o_v,
    output logic        [SQ_IN_W-1:0] o_sq_in,
    output t_side                     o_side
);

    // stage 1: offset
    logic               r1_v;
    logic signed [31:0] r1_d [3];
    logic signed [32:0] r1_l [3];
    logic        [30:0] r1_r;
    // stage 2: products
    logic               r2_v;
    logic signed [63:0] r2_dd [3];
    logic signed [64:0] r2_dl [3];
    logic signed [65:0] r2_ll [3];
    logic        [61:0] r2_rr;
    // stage 3: coefficients
    logic                  r3_v;
    logic [A_W-1:0]        r3_a;
    logic signed [H_W-1:0] r3_h;
    logic signed [C_W-1:0] r3_c;
    // stage 4: magnitudes and flags
    logic                  r4_v;
    logic [A_W-1:0]        r4_a;
    logic signed [H_W-1:0] r4_h;
    logic [64:0]           r4_hm;
    logic [65:0]           r4_cm;
    logic                  r4_azero, r4_hpos, r4_cneg, r4_czero;
    // stage 5: partial products
    logic                  r5_v;
    logic [A_W-1:0]        r5_a;
    logic signed [H_W-1:0] r5_h;
    logic                  r5_azero, r5_hpos, r5_cneg, r5_czero;
    logic [65:0]           r5_hll;
    logic [64:0]           r5_hlh;
    logic [63:0]           r5_hhh;
    logic [64:0]           r5_alcl, r5_alch, r5_ahcl, r5_ahch;
    // stage 6: h^2 and a*|c|
    logic                  r6_v;
    logic [A_W-1:0]        r6_a;
    logic signed [H_W-1:0] r6_h;
    logic                  r6_azero, r6_hpos, r6_cneg, r6_czero;
    logic [129:0]          r6_h2;
    logic [130:0]          r6_ac;
    // stage 7: discriminant
    logic                  r7_v;
    logic [SQ_IN_W-1:0]    r7_sq;
    t_side                 r7_side;

    logic signed [DISC_W-1:0] n_disc;
    logic                     n_dneg;

    // discriminant, sign of a*c follows c
    always_comb begin
        if (r6_cneg) begin
            n_disc = $signed({2'b00, r6_h2}) + $signed({1'b0, r6_ac});
        end else begin
            n_disc = $signed({2'b00, r6_h2}) - $signed({1'b0, r6_ac});
        end
        n_dneg = n_disc[DISC_W-1];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0;
            r5_v <= 1'b0; r6_v <= 1'b0; r7_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_v;  r2_v <= r1_v; r3_v <= r2_v; r4_v <= r3_v;
            r5_v <= r4_v; r6_v <= r5_v; r7_v <= r6_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_d[k]  <= i_dir[k];
                r1_l[k]  <= $signed({i_org[k][31], i_org[k]})
                          - $signed({i_cen[k][31], i_cen[k]});
                r2_dd[k] <= r1_d[k] * r1_d[k];
                r2_dl[k] <= r1_d[k] * r1_l[k];
                r2_ll[k] <= r1_l[k] * r1_l[k];
            end
            r1_r  <= i_rad;
            r2_rr <= r1_r * r1_r;

            r3_a <= r2_dd[0][63:0] + r2_dd[1][63:0] + r2_dd[2][63:0];
            r3_h <= $signed({r2_dl[0][64], r2_dl[0]}) + $signed({r2_dl[1][64], r2_dl[1]})
                  + $signed({r2_dl[2][64], r2_dl[2]});
            r3_c <= $signed({1'b0, r2_ll[0]}) + $signed({1'b0, r2_ll[1]})
                  + $signed({1'b0, r2_ll[2]}) - $signed({5'b0, r2_rr});

            r4_a     <= r3_a;
            r4_h     <= r3_h;
            r4_hm    <= r3_h[H_W-1] ? 65'(-r3_h) : r3_h[64:0];
            r4_cm    <= r3_c[C_W-1] ? 66'(-r3_c) : r3_c[65:0];
            r4_azero <= (r3_a == '0);
            r4_hpos  <= !r3_h[H_W-1] && (r3_h != '0);
            r4_cneg  <= r3_c[C_W-1];
            r4_czero <= (r3_c == '0);

            r5_a     <= r4_a;
            r5_h     <= r4_h;
            r5_azero <= r4_azero;
            r5_hpos  <= r4_hpos;
            r5_cneg  <= r4_cneg;
            r5_czero <= r4_czero;
            r5_hll   <= r4_hm[32:0] * r4_hm[32:0];
            r5_hlh   <= r4_hm[32:0] * r4_hm[64:33];
            r5_hhh   <= r4_hm[64:33] * r4_hm[64:33];
            r5_alcl  <= r4_a[31:0] * r4_cm[32:0];
            r5_alch  <= r4_a[31:0] * r4_cm[65:33];
            r5_ahcl  <= r4_a[63:32] * r4_cm[32:0];
            r5_ahch  <= r4_a[63:32] * r4_cm[65:33];

            r6_a     <= r5_a;
            r6_h     <= r5_h;
            r6_azero <= r5_azero;
            r6_hpos  <= r5_hpos;
            r6_cneg  <= r5_cneg;
            r6_czero <= r5_czero;
            r6_h2    <= {r5_hhh, 66'b0} + {31'b0, r5_hlh, 34'b0} + {64'b0, r5_hll};
            r6_ac    <= {1'b0, r5_ahch, 65'b0} + {33'b0, r5_alch, 33'b0}
                      + {34'b0, r5_ahcl, 32'b0} + {66'b0, r5_alcl};

            r7_sq             <= {n_disc, 32'b0};
            r7_side.miss      <= r6_azero || n_dneg || (r6_hpos && !r6_cneg && !r6_czero);
            r7_side.near_root <= !r6_hpos && !r6_cneg;
            r7_side.h         <= r6_h;
            r7_side.a         <= r6_a;
        end
    end

    assign o_v     = r7_v;
    assign o_sq_in = r7_sq;
    assign o_side  = r7_side;

endmodule

[hw/rtl/rsi_sqrt.sv]
// Pipelined restoring square root, one root bit per stage.
module rsi_sqrt
    import rsi_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_v,
    input  logic [SQ_IN_W-1:0]        i_x,
    input  t_side                     i_side,
    output logic                      o_v,
    output logic [SQ_OUT_W-1:0]       o_root,
    output logic                      o_exact,
    output t_side                     o_side
);

    logic                r_v    [1:SQ_OUT_W];
    logic [SQ_IN_W-1:0]  r_x    [1:SQ_OUT_W];
    logic [SQ_REM_W-1:0] r_rem  [1:SQ_OUT_W];
    logic [SQ_OUT_W-1:0] r_root [1:SQ_OUT_W];
    t_side               r_side [1:SQ_OUT_W];

    for (genvar g = 0; g < SQ_OUT_W; g++) begin : g_step
        logic                v_in;
        logic [SQ_IN_W-1:0]  x_in;
        logic [SQ_REM_W-1:0] rem_in, rem_sh, trial, n_rem;
        logic [SQ_OUT_W-1:0] root_in;
        t_side               side_in;
        logic                ge;

        if (g == 0) begin : g_first
            assign v_in    = i_v;
            assign x_in    = i_x;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[g];
            assign x_in    = r_x[g];
            assign rem_in  = r_rem[g];
            assign root_in = r_root[g];
            assign side_in = r_side[g];
        end

        // bring down two bits, try root*4+1
        always_comb begin
            rem_sh = {rem_in[SQ_REM_W-3:0], x_in[SQ_IN_W-1 -: 2]};
            trial  = {root_in, 2'b01};
            ge     = (rem_sh >= trial);
            n_rem  = ge ? rem_sh - trial : rem_sh;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g+1]    <= {x_in[SQ_IN_W-3:0], 2'b00};
                r_rem[g+1]  <= n_rem;
                r_root[g+1] <= {root_in[SQ_OUT_W-2:0], ge};
                r_side[g+1] <= side_in;
            end
        end
    end

    assign o_v     = r_v[SQ_OUT_W];
    assign o_root  = r_root[SQ_OUT_W];
    assign o_exact = (r_rem[SQ_OUT_W] == '0);
    assign o_side  = r_side[SQ_OUT_W];

endmodule

[hw/rtl/rsi_div.sv]
// Root selection and pipelined division of the numerator by a.
module rsi_div
    import rsi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_v,
    input  logic [SQ_OUT_W-1:0]   i_root,
    input  logic                  i_exact,
    input  t_side                 i_side,
    output logic                  o_v,
    output logic                  o_hit,
    output logic [Q_W-1:0]        o_dist
);

    localparam int NX_W = NUM_W + 1;

    // stage A: numerator
    logic             ra_v, ra_miss;
    logic [NUM_W-1:0] ra_num;
    logic [A_W-1:0]   ra_a;
    // stage B: saturation and first remainder
    logic             rb_v, rb_miss, rb_sat;
    logic [A_W-1:0]   rb_a;
    logic [A_W:0]     rb_rem;
    logic [Q_W-1:0]   rb_low;

    logic [NX_W-1:0] n_hx, n_sx, n_num;

    // N = -h*2^16, then minus ceil(s) or plus s
    always_comb begin
        n_hx = {{(NX_W-H_W-16){i_side.h[H_W-1]}}, i_side.h, 16'b0};
        n_sx = {{(NX_W-SQ_OUT_W){1'b0}}, i_root};
        if (i_side.near_root) begin
            n_num = -n_hx - n_sx - {{(NX_W-1){1'b0}}, !i_exact};
        end else begin
            n_num = n_sx - n_hx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_v <= 1'b0;
            rb_v <= 1'b0;
        end else if (i_en) begin
            ra_v <= i_v;
            rb_v <= ra_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_miss <= i_side.miss;
            ra_a    <= i_side.a;
            ra_num  <= n_num[NX_W-1] ? '0 : n_num[NUM_W-1:0];

            rb_miss <= ra_miss;
            rb_a    <= ra_a;
            rb_sat  <= ({{(A_W+Q_W-NUM_W){1'b0}}, ra_num} >= {ra_a, {Q_W{1'b0}}});
            rb_rem  <= {{(A_W+1-(NUM_W-Q_W)){1'b0}}, ra_num[NUM_W-1:Q_W]};
            rb_low  <= ra_num[Q_W-1:0];
        end
    end

    // restoring division, one quotient bit per stage
    logic           r_v    [1:Q_W];
    logic           r_miss [1:Q_W];
    logic           r_sat  [1:Q_W];
    logic [A_W-1:0] r_a    [1:Q_W];
    logic [A_W:0]   r_rem  [1:Q_W];
    logic [Q_W-1:0] r_low  [1:Q_W];
    logic [Q_W-1:0] r_q    [1:Q_W];

    for (genvar g = 0; g < Q_W; g++) begin : g_step
        logic           v_in, miss_in, sat_in, ge;
        logic [A_W-1:0] a_in;
        logic [A_W:0]   rem_in, rem_sh, n_rem;
        logic [Q_W-1:0] low_in, q_in;

        if (g == 0) begin : g_first
            assign v_in    = rb_v;
            assign miss_in = rb_miss;
            assign sat_in  = rb_sat;
            assign a_in    = rb_a;
            assign rem_in  = rb_rem;
            assign low_in  = rb_low;
            assign q_in    = '0;
        end else begin : g_next
            assign v_in    = r_v[g];
            assign miss_in = r_miss[g];
            assign sat_in  = r_sat[g];
            assign a_in    = r_a[g];
            assign rem_in  = r_rem[g];
            assign low_in  = r_low[g];
            assign q_in    = r_q[g];
        end

        always_comb begin
            rem_sh = {rem_in[A_W-1:0], low_in[Q_W-1]};
            ge     = (rem_sh >= {1'b0, a_in});
            n_rem  = ge ? rem_sh - {1'b0, a_in} : rem_sh;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_miss[g+1] <= miss_in;
                r_sat[g+1]  <= sat_in;
                r_a[g+1]    <= a_in;
                r_rem[g+1]  <= n_rem;
                r_low[g+1]  <= {low_in[Q_W-2:0], 1'b0};
                r_q[g+1]    <= {q_in[Q_W-2:0], ge};
            end
        end
    end

    // pick the reported distance
    always_comb begin
        o_v   = r_v[Q_W];
        o_hit = !r_miss[Q_W];
        if (r_miss[Q_W]) begin
            o_dist = '0;
        end else if (r_sat[Q_W]) begin
            o_dist = '1;
        end else begin
            o_dist = r_q[Q_W];
        end
    end

endmodule

[hw/rtl/ray_sphere_intersect.sv]
// Top level of the ray/sphere intersection pipeline.
// Takes one ray per cycle while the output is not stalled and returns one
// result per ray, in order, through 7 stages of coefficient and discriminant
// arithmetic, 82 square-root stages (one root bit each), 2 stages to form
// the numerator and test for saturation, 32 divider stages (one quotient
// bit each) and the output register. A stall on the output side freezes the
// whole pipeline, so s_axis_tready follows m_axis_tready whenever the output
// register is full. The user must write sphere center and radius through the
// config port only while no ray is in flight; the block does not enforce it.
module ray_sphere_intersect
    import rsi_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write port
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    // ray input
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] origin_x, [63:32] origin_y, [95:64] origin_z,
    // [127:96] dir_x, [159:128] dir_y, [191:160] dir_z
    input  logic [191:0] s_axis_tdata,
    // result output
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] hit_distance
    output logic [31:0]  m_axis_tdata,
    // [0] hit
    output logic         m_axis_tuser
);

    logic signed [31:0] r_cen [3];
    logic        [30:0] r_rad;
    logic               r_out_v;
    logic               r_out_hit;
    logic [Q_W-1:0]     r_out_dist;

    logic               en;
    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];

    logic                f_v;
    logic [SQ_IN_W-1:0]  f_sq;
    t_side               f_side;
    logic                s_v, s_exact;
    logic [SQ_OUT_W-1:0] s_root;
    t_side               s_side;
    logic                d_v, d_hit;
    logic [Q_W-1:0]      d_dist;

    // advance the pipeline unless a result is held
    assign en            = !r_out_v || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            org[k] = s_axis_tdata[32*k +: 32];
            dir[k] = s_axis_tdata[96 + 32*k +: 32];
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cen[0] <= '0;
            r_cen[1] <= '0;
            r_cen[2] <= '0;
            r_rad    <= 31'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_X: r_cen[0] <= i_cfg_data;
                CFG_CENTER_Y: r_cen[1] <= i_cfg_data;
                CFG_CENTER_Z: r_cen[2] <= i_cfg_data;
                CFG_RADIUS:   r_rad    <= i_cfg_data[30:0];
                default:      r_rad    <= r_rad;
            endcase
        end
    end

    rsi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (s_axis_tvalid),
        .i_org   (org),
        .i_dir   (dir),
        .i_cen   (r_cen),
        .i_rad   (r_rad),
        .o_v     (f_v),
        .o_sq_in (f_sq),
        .o_side  (f_side)
    );

    rsi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (f_v),
        .i_x     (f_sq),
        .i_side  (f_side),
        .o_v     (s_v),
        .o_root  (s_root),
        .o_exact (s_exact),
        .o_side  (s_side)
    );

    rsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (s_v),
        .i_root  (s_root),
        .i_exact (s_exact),
        .i_side  (s_side),
        .o_v     (d_v),
        .o_hit   (d_hit),
        .o_dist  (d_dist)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_hit  <= d_hit;
            r_out_dist <= d_dist;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_dist;
    assign m_axis_tuser  = r_out_hit;

endmodule

[tb/ray_sphere_intersect_checker.sv]
// Result checker for the ray/sphere intersection block: predicts and compares.
module ray_sphere_intersect_checker
    import rsi_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [31:0]  m_axis_tdata,
    input  logic         m_axis_tuser,
    output int           o_mismatches,
    output int           o_pending
);

    typedef struct packed {
        logic        hit;
        logic [31:0] distance;
    } t_hit;

    logic [31:0] sph_cx, sph_cy, sph_cz;
    logic [30:0] sph_r;
    t_hit        hit_q[$];
    int          errs;

    assign o_mismatches = errs;
    assign o_pending    = hit_q.size();

    // Floor square root of a non-negative 192-bit value
    function automatic logic [191:0] floor_sqrt(logic [191:0] x);
        logic [191:0] res;
        logic [191:0] trial;
        res = '0;
        for (int i = 95; i >= 0; i--) begin
            trial = res | (192'd1 << i);
            if (trial * trial <= x) res = trial;
        end
        return res;
    endfunction

    // Nearest non-negative intersection of one ray with the current sphere
    function automatic t_hit trace_ray(logic [191:0] ray);
        logic signed [191:0] dx, dy, dz, lx, ly, lz, tmp;
        logic signed [191:0] a, h, c, r2, dsc, sc, s, num;
        logic [191:0]        q;
        t_hit                res;
        res = '0;
        dx = $signed(ray[127:96]);
        dy = $signed(ray[159:128]);
        dz = $signed(ray[191:160]);
        lx = $signed(ray[31:0]);  tmp = $signed(sph_cx); lx = lx - tmp;
        ly = $signed(ray[63:32]); tmp = $signed(sph_cy); ly = ly - tmp;
        lz = $signed(ray[95:64]); tmp = $signed(sph_cz); lz = lz - tmp;
        r2 = {161'd0, sph_r};
        r2 = r2 * r2;
        a = dx * dx + dy * dy + dz * dz;
        h = dx * lx + dy * ly + dz * lz;
        c = lx * lx + ly * ly + lz * lz - r2;
        // zero direction and negative discriminant miss
        if (a == 0) return res;
        dsc = h * h - a * c;
        if (dsc < 0) return res;
        sc  = dsc <<< 32;
        s   = $signed(floor_sqrt(sc));
        num = -(h * 65536);
        if (!(h > 0) && !(c < 0)) begin
            // smaller root: round the root up so the quotient floors exactly
            if (s * s != sc) s = s + 1;
            num = num - s;
        end else if (!(h > 0) || c < 0 || c == 0) begin
            num = num + s;
        end else begin
            return res;
        end
        if (num < 0) num = 0;
        q = $unsigned(num) / $unsigned(a);
        res.hit      = 1'b1;
        res.distance = (q > 192'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_hit got;
        t_hit want;
        if (!i_rst_n) begin
            sph_cx <= '0;
            sph_cy <= '0;
            sph_cz <= '0;
            sph_r  <= 31'd65536;
            errs   <= 0;
        end else begin
            // track register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CENTER_X: sph_cx <= i_cfg_data;
                    CFG_CENTER_Y: sph_cy <= i_cfg_data;
                    CFG_CENTER_Z: sph_cz <= i_cfg_data;
                    CFG_RADIUS:   sph_r  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            // predict each accepted ray
            if (s_axis_tvalid && s_axis_tready) hit_q.push_back(trace_ray(s_axis_tdata));
            // compare each result transaction with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                got.hit      = m_axis_tuser;
                got.distance = m_axis_tdata;
                if (hit_q.size() == 0) begin
                    if (errs < 10) $display("unexpected result hit=%0b dist=%h",
                                            got.hit, got.distance);
                    errs <= errs + 1;
                end else begin
                    want = hit_q.pop_front();
                    if (got != want) begin
                        if (errs < 10)
                            $display("result mismatch: hit exp %0b got %0b, dist exp %h got %h",
                                     want.hit, got.hit, want.distance, got.distance);
                        errs <= errs + 1;
                    end
                end
            end
        end
    end

endmodule

[tb/ray_sphere_intersect_tb.sv]
// Stimulus and verdict for the ray/sphere intersection block.
module ray_sphere_intersect_tb;
    import rsi_pkg::*;

    localparam int LATENCY     = 125;
    localparam int STALL_LIMIT = 20000;
    localparam int RAYS_PER_PH = 370;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_idx = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [31:0]  m_axis_tdata;
    logic         m_axis_tuser;

    int          mismatches, pending;
    int          rays_sent = 0;
    int          idle_cycles = 0;
    logic [31:0] cen[3];
    logic [30:0] rad;

    always #5 i_clk = ~i_clk;

    ray_sphere_intersect dut (.*);

    ray_sphere_intersect_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .o_mismatches(mismatches), .o_pending(pending)
    );

    // Abort when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver backpressure: changing patterns plus one long hold-off
    initial begin
        int  mode;
        bit  long_done;
        mode = 0;
        long_done = 0;
        forever begin
            @(posedge i_clk);
            if (!long_done && rays_sent >= 200) begin
                long_done = 1;
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                2: m_axis_tready <= ($urandom_range(0, 7) != 0);
                default: m_axis_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Load a new sphere once the pipeline has drained
    task automatic load_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               logic [30:0] r);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        write_reg(CFG_RADIUS, {1'b0, r});
        cen[0] = cx; cen[1] = cy; cen[2] = cz; rad = r;
    endtask

    // Offer one ray, hold it until taken, then maybe leave a gap
    task automatic send_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dz, dy, dx, oz, oy, ox};
        do @(posedge i_clk); while (!s_axis_tready);
        rays_sent++;
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Random ray: mostly aimed near the sphere, some from inside, some raw bits
    task automatic send_random_ray();
        logic [31:0] o[3], d[3];
        int kind, sh;
        kind = $urandom_range(0, 9);
        sh = $urandom_range(2, 26);
        for (int k = 0; k < 3; k++) begin
            case (kind)
                0, 1: begin
                    o[k] = $urandom;
                    d[k] = $urandom;
                end
                2, 3: begin
                    o[k] = cen[k] + ($signed({1'b0, rad}) >>> 2) * ($urandom_range(0, 2) - 1);
                    d[k] = $signed($urandom) >>> sh;
                end
                default: begin
                    o[k] = cen[k] + ($signed($urandom) >>> sh);
                    d[k] = cen[k] - o[k] + ($signed($urandom) >>> $urandom_range(6, 31));
                    if ($urandom_range(0, 4) == 0) d[k] = -d[k];
                end
            endcase
        end
        if ($urandom_range(0, 40) == 0) begin
            d[0] = '0; d[1] = '0; d[2] = '0;
        end
        send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    endtask

    initial begin
        cen[0] = '0; cen[1] = '0; cen[2] = '0; rad = 31'd65536;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rays against the unit sphere at the origin
        send_ray('0, '0, '0, '0, '0, '0);                          // zero direction
        send_ray(32'hFFFB_0000, '0, '0, 32'h0001_0000, '0, '0);    // head-on hit
        send_ray('0, '0, '0, 32'h0001_0000, '0, '0);               // from the center
        send_ray(32'h0005_0000, '0, '0, 32'h0001_0000, '0, '0);    // sphere behind
        send_ray(32'hFFFB_0000, 32'h0001_0000, '0, 32'h0001_0000, '0, '0); // tangent
        send_ray(32'hFFFB_0000, 32'h0002_0000, '0, 32'h0001_0000, '0, '0); // clear miss
        send_ray(32'h8AD0_0000, '0, '0, 32'h0000_0001, '0, '0);    // saturating distance
        send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_ray('0, 32'h0000_8000, '0, '0, '0, 32'h8000_0000);    // inside, large dir
        send_ray('0, '0, 32'h0001_0000, '0, '0, 32'h0001_0000);    // on the surface, out
        send_ray('0, '0, 32'h0001_0000, '0, '0, 32'hFFFF_0000);    // on the surface, in
        repeat (RAYS_PER_PH) send_random_ray();

        // zero radius at extreme center: hits only through the center
        load_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h0003_0000, 31'd0);
        send_ray(32'h7FFF_0000, 32'h8000_0000, 32'h0003_0000, 32'h0000_FFFF, '0, '0);
        send_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h0003_0000, 32'h0001_0000, '0, '0);
        repeat (RAYS_PER_PH) send_random_ray();

        // widest radius with opposite extreme center
        load_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
        send_ray('0, '0, '0, 32'h0001_0000, 32'h0001_0000, '0);
        repeat (RAYS_PER_PH) send_random_ray();

        // small sphere near the origin
        load_sphere(32'h0002_8000, 32'hFFFE_0000, 32'h0000_4000, 31'd196608);
        repeat (RAYS_PER_PH) send_random_ray();

        // random sphere
        load_sphere($urandom, $urandom, $urandom, 31'($urandom));
        repeat (RAYS_PER_PH) send_random_ray();

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[ray_sphere_intersect.f]
hw/rtl/rsi_pkg.sv
hw/rtl/rsi_front.sv
hw/rtl/rsi_sqrt.sv
hw/rtl/rsi_div.sv
hw/rtl/ray_sphere_intersect.sv
tb/ray_sphere_intersect_checker.sv
tb/ray_sphere_intersect_tb.sv
